/* design/fmt_pkg.sv */
// Shared types, codes and constants of the tuner serial word sender.
// Used by the top level, the front end, the command queue and the back end.
package fmt_pkg;

	localparam int WORD_BITS_DEFAULT = 14;
	localparam int MAX_WORD_BITS     = 16;
	localparam int QUEUE_DEPTH       = 2;

	localparam logic [9:0]  PORT_ADDR_RESET = 10'd524;
	localparam logic [17:0] FREQ_OFFSET     = 18'd10520;
	localparam logic [30:0] FREQ_SCALE      = 31'd7825;
	// Rounded-up reciprocal of 100000 scaled by 2^48; exact for products below 2^31.
	localparam logic [31:0] RECIP_100000    = 32'd2814749768;
	localparam int          RECIP_SHIFT     = 48;

	localparam logic [7:0] BYTE_FRAME_LOW = 8'h03;
	localparam logic [7:0] BYTE_CLK_HIGH  = 8'h07;
	localparam logic [7:0] BYTE_ZERO_LOW  = 8'h04;
	localparam logic [7:0] BYTE_ZERO_HIGH = 8'h05;
	localparam logic [7:0] BYTE_ONE_LOW   = 8'h06;
	localparam logic [7:0] BYTE_MUTE      = 8'h10;
	localparam logic [7:0] BYTE_UNMUTE    = 8'h20;

	typedef enum logic [1:0] {
		OP_SET_FREQ = 2'd0,
		OP_MUTE     = 2'd1,
		OP_UNMUTE   = 2'd2,
		OP_READ_SIG = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		KIND_PAIR   = 2'd0,
		KIND_SINGLE = 2'd1,
		KIND_REPORT = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		CMD_FRAME  = 2'd0,
		CMD_SINGLE = 2'd1,
		CMD_REPORT = 2'd2
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t                  kind;
		logic [7:0]                 code;
		logic [MAX_WORD_BITS-1:0]   word;
		logic                       signal_present;
	} cmd_t;

endpackage

/* design/fmt_if.sv */
// Valid/ready channel interfaces for command items and result items.
// Depends on fmt_pkg for nothing but is compiled after it.
interface fmt_cmd_if;
	logic        valid;
	logic        ready;
	logic [1:0]  op;
	logic [20:0] frequency;
	logic [7:0]  port_status;

	modport source (output valid, output op, output frequency, output port_status,
		input ready);
	modport sink (input valid, input op, input frequency, input port_status,
		output ready);
endinterface

interface fmt_res_if;
	logic       valid;
	logic       ready;
	logic [1:0] kind;
	logic [9:0] port_address;
	logic [7:0] first_byte;
	logic [7:0] second_byte;
	logic       signal_present;
	logic       last;

	modport source (output valid, output kind, output port_address, output first_byte,
		output second_byte, output signal_present, output last, input ready);
	modport sink (input valid, input kind, input port_address, input first_byte,
		input second_byte, input signal_present, input last, output ready);
endinterface

/* design/fm_tuner_serial_word_sender.sv */
// Top level of the tuner serial word sender: front end, command queue, back end.
// An item passes the two front-end stages and the queue into the output register.
// A set-frequency item sends WORD_BITS + 20 frame slots (34 by default), one slot per
// cycle unless res.ready stalls it, others one result. Items are accepted every cycle
// while the queue has room; a busy back end stalls the input once the queue fills.
// Reset sets the muted state, loads port address 524 and empties all stages.
module fm_tuner_serial_word_sender #(
	parameter int WORD_BITS = fmt_pkg::WORD_BITS_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [9:0]  cfg_wdata,
	fmt_cmd_if.sink     cmd,
	fmt_res_if.source   res
);

	logic [9:0]     port_addr_q;
	logic           push, q_full, pop, q_empty;
	fmt_pkg::cmd_t  push_data, q_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			port_addr_q <= fmt_pkg::PORT_ADDR_RESET;
		end else if (cfg_we) begin
			port_addr_q <= cfg_wdata;
		end
	end

	fmt_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.push      (push),
		.push_data (push_data),
		.q_full    (q_full)
	);

	fmt_queue #(
		.DEPTH (fmt_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (q_full),
		.pop       (pop),
		.pop_data  (q_data),
		.empty     (q_empty)
	);

	fmt_back #(
		.WORD_BITS (WORD_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.port_addr (port_addr_q),
		.q_data    (q_data),
		.q_empty   (q_empty),
		.pop       (pop),
		.res       (res)
	);

endmodule

/* design/fmt_front.sv */
// Front end: accepts command items, computes the tuning word in two
// multiply stages, tracks the muted state and pushes commands. Uses fmt_pkg.
module fmt_front (
	input  logic            clk,
	input  logic            arst_n,
	fmt_cmd_if.sink         cmd,
	output logic            push,
	output fmt_pkg::cmd_t   push_data,
	input  logic            q_full
);

	logic                 v_s1, v_s2;
	fmt_pkg::op_t         op_s1, op_s2;
	logic                 stat_s1, stat_s2;
	logic [30:0]          prod_s1;
	logic [62:0]          prod_s2;
	logic                 muted_q;
	logic                 emit;
	logic                 en;
	logic [17:0]          sum;

	assign sum = {1'b0, cmd.frequency[20:4]} + fmt_pkg::FREQ_OFFSET;

	always_comb begin
		case (op_s2)
			fmt_pkg::OP_SET_FREQ: emit = 1'b1;
			fmt_pkg::OP_MUTE:     emit = !muted_q;
			fmt_pkg::OP_UNMUTE:   emit = muted_q;
			fmt_pkg::OP_READ_SIG: emit = 1'b1;
			default:              emit = 1'b0;
		endcase
	end

	assign en        = !(v_s2 && emit && q_full);
	assign cmd.ready = en;
	assign push      = v_s2 && emit;

	always_comb begin
		push_data                = '0;
		push_data.word           = fmt_pkg::MAX_WORD_BITS'(prod_s2[62:fmt_pkg::RECIP_SHIFT]);
		push_data.signal_present = !stat_s2;
		case (op_s2)
			fmt_pkg::OP_SET_FREQ: push_data.kind = fmt_pkg::CMD_FRAME;
			fmt_pkg::OP_MUTE: begin
				push_data.kind = fmt_pkg::CMD_SINGLE;
				push_data.code = fmt_pkg::BYTE_MUTE;
			end
			fmt_pkg::OP_UNMUTE: begin
				push_data.kind = fmt_pkg::CMD_SINGLE;
				push_data.code = fmt_pkg::BYTE_UNMUTE;
			end
			default: push_data.kind = fmt_pkg::CMD_REPORT;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			muted_q <= 1'b1;
		end else if (en) begin
			v_s1 <= cmd.valid;
			v_s2 <= v_s1;
			if (v_s2 && op_s2 == fmt_pkg::OP_MUTE) begin
				muted_q <= 1'b1;
			end else if (v_s2 && op_s2 == fmt_pkg::OP_UNMUTE) begin
				muted_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			op_s1   <= fmt_pkg::op_t'(cmd.op);
			stat_s1 <= cmd.port_status[3];
			prod_s1 <= 31'(sum) * fmt_pkg::FREQ_SCALE;
			op_s2   <= op_s1;
			stat_s2 <= stat_s1;
			prod_s2 <= 63'(prod_s1) * 63'(fmt_pkg::RECIP_100000);
		end
	end

endmodule

/* design/fmt_queue.sv */
// Short command queue between the front end and the back end.
// Holds fmt_pkg::cmd_t entries in a small register array.
module fmt_queue #(
	parameter int DEPTH = fmt_pkg::QUEUE_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  fmt_pkg::cmd_t  push_data,
	output logic           full,
	input  logic           pop,
	output fmt_pkg::cmd_t  pop_data,
	output logic           empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	fmt_pkg::cmd_t   mem_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            do_push, do_pop;

	assign full     = count_q == CW'(DEPTH);
	assign empty    = count_q == '0;
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

/* design/fmt_back.sv */
// Back end: takes commands from the queue and sends the result items,
// one frame slot per cycle unless res.ready stalls, through an output register. Uses fmt_pkg.
module fmt_back #(
	parameter int WORD_BITS = fmt_pkg::WORD_BITS_DEFAULT
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic [9:0]     port_addr,
	input  fmt_pkg::cmd_t  q_data,
	input  logic           q_empty,
	output logic           pop,
	fmt_res_if.source      res
);

	localparam int SLOTS = WORD_BITS + 20;
	localparam int SW    = $clog2(SLOTS);
	localparam int IW    = $clog2(fmt_pkg::MAX_WORD_BITS);

	logic                             busy_q;
	logic [SW-1:0]                    slot_q;
	logic [fmt_pkg::MAX_WORD_BITS-1:0] word_q;
	logic                             ov_q;
	fmt_pkg::kind_t                   kind_q;
	logic [7:0]                       b1_q, b2_q;
	logic                             sig_q, last_q;
	logic                             load;
	logic [SW-1:0]                    tail;
	logic                             bit_val;
	logic                             edge_slot;
	logic [7:0]                       slot_b1, slot_b2;

	assign load = !ov_q || res.ready;
	assign pop  = load && !busy_q && !q_empty;

	always_comb begin
		tail      = slot_q - SW'(WORD_BITS + 1);
		edge_slot = (slot_q == '0) || (slot_q == SW'(SLOTS - 1));
		if (slot_q <= SW'(WORD_BITS)) begin
			bit_val = word_q[IW'(slot_q - 1'b1)];
		end else begin
			bit_val = (tail == SW'(11)) || (tail == SW'(16));
		end
		if (edge_slot) begin
			slot_b1 = fmt_pkg::BYTE_FRAME_LOW;
			slot_b2 = fmt_pkg::BYTE_CLK_HIGH;
		end else if (bit_val) begin
			slot_b1 = fmt_pkg::BYTE_ONE_LOW;
			slot_b2 = fmt_pkg::BYTE_CLK_HIGH;
		end else begin
			slot_b1 = fmt_pkg::BYTE_ZERO_LOW;
			slot_b2 = fmt_pkg::BYTE_ZERO_HIGH;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q   <= 1'b0;
			busy_q <= 1'b0;
			slot_q <= '0;
		end else if (load) begin
			if (busy_q) begin
				ov_q   <= 1'b1;
				slot_q <= slot_q + 1'b1;
				if (slot_q == SW'(SLOTS - 1)) begin
					busy_q <= 1'b0;
				end
			end else if (!q_empty) begin
				ov_q <= 1'b1;
				if (q_data.kind == fmt_pkg::CMD_FRAME) begin
					busy_q <= 1'b1;
					slot_q <= SW'(1);
				end
			end else begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			word_q <= q_data.word;
		end
		if (load && busy_q) begin
			kind_q <= fmt_pkg::KIND_PAIR;
			b1_q   <= slot_b1;
			b2_q   <= slot_b2;
			sig_q  <= 1'b0;
			last_q <= slot_q == SW'(SLOTS - 1);
		end else if (pop) begin
			case (q_data.kind)
				fmt_pkg::CMD_FRAME: begin
					kind_q <= fmt_pkg::KIND_PAIR;
					b1_q   <= fmt_pkg::BYTE_FRAME_LOW;
					b2_q   <= fmt_pkg::BYTE_CLK_HIGH;
					sig_q  <= 1'b0;
					last_q <= 1'b0;
				end
				fmt_pkg::CMD_SINGLE: begin
					kind_q <= fmt_pkg::KIND_SINGLE;
					b1_q   <= q_data.code;
					b2_q   <= 8'h00;
					sig_q  <= 1'b0;
					last_q <= 1'b1;
				end
				default: begin
					kind_q <= fmt_pkg::KIND_REPORT;
					b1_q   <= 8'h00;
					b2_q   <= 8'h00;
					sig_q  <= q_data.signal_present;
					last_q <= 1'b1;
				end
			endcase
		end
	end

	assign res.valid          = ov_q;
	assign res.kind           = kind_q;
	assign res.port_address   = port_addr;
	assign res.first_byte     = b1_q;
	assign res.second_byte    = b2_q;
	assign res.signal_present = sig_q;
	assign res.last           = last_q;

endmodule
